FILE: hw/rtl/tknm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tknm_pkg
// Shared types and constants of the two-key nearest table match unit.
// ---------------------------------------------------------------------------
package tknm_pkg;

   localparam int VAL_W  = 16;
   localparam int DIST_W = 17;
   localparam int CNT_W  = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] START_DIST = 17'd25344;

   localparam logic [CSR_IDX_W-1:0] CSR_TOL_TEMP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_DENSITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd2;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PASS1  = 4'b0010,
      ST_PASS2  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] temp;
      logic [VAL_W-1:0]        density;
      logic [VAL_W-1:0]        molarity;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: hw/rtl/tknm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tknm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tknm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/two_key_nearest_table_match_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_key_nearest_table_match_unit
// Table of temperature, density and molarity entries with a two-pass
// nearest-match query.
// ---------------------------------------------------------------------------
// A load beat writes one table entry. A query beat runs two passes over
// entries 0 .. n-1 (n is entry_count, clamped to the table depth) through
// one shared absolute-difference and compare unit that reads the table RAM
// one entry per cycle, and the input stays stalled while the query runs;
// a query whose temperature match is rejected skips the second pass. The
// result waits in an output register, and a finished query holds until
// that register is free.
module two_key_nearest_table_match_unit
   import tknm_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [5:0]              req_entry_index,
   input  logic signed [VAL_W-1:0] req_temp,
   input  logic [VAL_W-1:0]        req_density,
   input  logic [VAL_W-1:0]        req_molarity,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic [VAL_W-1:0]        rsp_result_molarity,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_wr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int N_W   = $clog2(TABLE_DEPTH + 1);

   // load index folded into the table depth
   logic [IDX_W-1:0] wr_idx_lut [64];
   for (genvar k = 0; k < 64; k++) begin : g_lut
      assign wr_idx_lut[k] = IDX_W'(k % TABLE_DEPTH);
   end

   state_type               state_ff, state_in;
   logic [VAL_W-1:0]        tol_temp_ff, tol_temp_in;
   logic [VAL_W-1:0]        tol_density_ff, tol_density_in;
   logic [CNT_W-1:0]        entry_count_ff, entry_count_in;
   logic [N_W-1:0]          n_ff, n_in;
   logic [N_W-1:0]          idx_ff, idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic signed [VAL_W-1:0] qt_ff, qt_in;
   logic [VAL_W-1:0]        qd_ff, qd_in;
   logic [DIST_W-1:0]       best_ff, best_in;
   logic signed [VAL_W-1:0] chosen_ff, chosen_in;
   logic [VAL_W-1:0]        mol_ff, mol_in;
   logic                    res_found_ff, res_found_in;
   logic [VAL_W-1:0]        res_mol_ff, res_mol_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0]        rsp_mol_ff, rsp_mol_in;

   logic                    req_accept;
   logic                    issue;
   logic                    ram_wr_en;
   logic [ENTRY_W-1:0]      ram_rd_data;
   entry_type               wr_entry;
   entry_type               rd_entry;
   logic signed [DIST_W-1:0] op_a;
   logic signed [DIST_W-1:0] op_b;
   logic signed [DIST_W:0]   diff;
   logic [DIST_W-1:0]        gap;
   logic                     closer;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign ram_wr_en  = req_accept && (req_func == FUNC_LOAD);
   assign issue      = ((state_ff == ST_PASS1) || (state_ff == ST_PASS2)) && (idx_ff < n_ff);

   assign wr_entry.temp     = req_temp;
   assign wr_entry.density  = req_density;
   assign wr_entry.molarity = req_molarity;
   assign rd_entry          = entry_type'(ram_rd_data);

   tknm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_lut[req_entry_index]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // shared distance unit
   always_comb begin
      if (state_ff == ST_PASS1) begin
         op_a = DIST_W'(qt_ff);
         op_b = DIST_W'(rd_entry.temp);
      end else begin
         op_a = $signed({1'b0, qd_ff});
         op_b = $signed({1'b0, rd_entry.density});
      end
      diff   = (DIST_W + 1)'(op_a) - (DIST_W + 1)'(op_b);
      gap    = diff[DIST_W] ? DIST_W'(-diff) : DIST_W'(diff);
      closer = (gap < best_ff);
   end

   always_comb begin
      state_in       = state_ff;
      tol_temp_in    = tol_temp_ff;
      tol_density_in = tol_density_ff;
      entry_count_in = entry_count_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      rd_vld_in      = issue;
      qt_in          = qt_ff;
      qd_in          = qd_ff;
      best_in        = best_ff;
      chosen_in      = chosen_ff;
      mol_in         = mol_ff;
      res_found_in   = res_found_ff;
      res_mol_in     = res_mol_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_found_in   = rsp_found_ff;
      rsp_mol_in     = rsp_mol_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOL_TEMP:    tol_temp_in    = csr_wr_data;
            CSR_TOL_DENSITY: tol_density_in = csr_wr_data;
            CSR_ENTRY_COUNT: entry_count_in = csr_wr_data[CNT_W-1:0];
            default: ;
         endcase
      end

      if (issue) begin
         idx_in = idx_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_func == FUNC_QUERY)) begin
               state_in  = ST_PASS1;
               qt_in     = req_temp;
               qd_in     = req_density;
               idx_in    = '0;
               best_in   = START_DIST;
               chosen_in = '0;
               mol_in    = '0;
               if (32'(entry_count_ff) > 32'(TABLE_DEPTH)) begin
                  n_in = N_W'(TABLE_DEPTH);
               end else begin
                  n_in = N_W'(entry_count_ff);
               end
            end
         end
         ST_PASS1: begin
            if (rd_vld_ff && closer) begin
               best_in   = gap;
               chosen_in = rd_entry.temp;
            end
            if (!issue && !rd_vld_ff) begin
               if (best_ff > DIST_W'(tol_temp_ff)) begin
                  res_found_in = 1'b0;
                  res_mol_in   = '0;
                  state_in     = ST_RESULT;
               end else begin
                  best_in  = START_DIST;
                  idx_in   = '0;
                  state_in = ST_PASS2;
               end
            end
         end
         ST_PASS2: begin
            if (rd_vld_ff && (rd_entry.temp == chosen_ff) && closer) begin
               best_in = gap;
               mol_in  = rd_entry.molarity;
            end
            if (!issue && !rd_vld_ff) begin
               if (best_ff > DIST_W'(tol_density_ff)) begin
                  res_found_in = 1'b0;
                  res_mol_in   = '0;
               end else begin
                  res_found_in = 1'b1;
                  res_mol_in   = mol_ff;
               end
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_mol_in   = res_mol_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tol_temp_ff    <= 16'd256;
         tol_density_ff <= 16'd256;
         entry_count_ff <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tol_temp_ff    <= tol_temp_in;
         tol_density_ff <= tol_density_in;
         entry_count_ff <= entry_count_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      qt_ff        <= qt_in;
      qd_ff        <= qd_in;
      best_ff      <= best_in;
      chosen_ff    <= chosen_in;
      mol_ff       <= mol_in;
      res_found_ff <= res_found_in;
      res_mol_ff   <= res_mol_in;
      rsp_found_ff <= rsp_found_in;
      rsp_mol_ff   <= rsp_mol_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_result_molarity = rsp_mol_ff;

   // a new result beat only comes out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result beat raised outside result state");

   // read data only returns while a pass is running
   a_rd_in_pass: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ((state_ff == ST_PASS1) || (state_ff == ST_PASS2)))
      else $error("table read data outside a pass");

   // scan index never runs past the clamped count
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PASS1) || (state_ff == ST_PASS2)) |-> (idx_ff <= n_ff))
      else $error("scan index beyond entry count");

   // best distance never grows above its start value
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PASS1) || (state_ff == ST_PASS2)) |-> (best_ff <= START_DIST))
      else $error("best distance above start value");

endmodule
